### src/hrs_pkg.sv
package hrs_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CMD_W         = 2;
   localparam int SN_W          = 64;
   localparam int DATA_W        = 32;
   localparam int SLOT_W        = SN_W + DATA_W;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DROP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [SN_W-1:0] SN_UNKNOWN = 64'hFFFF_FFFF_0000_0000;

   typedef struct packed {
      logic start;
      logic valid;
      logic lookup;
   } scan_ctl_type;

endpackage

### src/hrs_ring_mem.sv
module hrs_ring_mem #(
   parameter int DEPTH = hrs_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [hrs_pkg::SLOT_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [hrs_pkg::SLOT_W-1:0]        rd_data
);
   import hrs_pkg::*;

   logic [SLOT_W-1:0] slot_ff [DEPTH];
   logic [SLOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/hrs_scan_unit.sv
module hrs_scan_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  hrs_pkg::scan_ctl_type         ctl,
   input  logic [hrs_pkg::SN_W-1:0]      key,
   input  logic [hrs_pkg::SN_W-1:0]      slot_sn,
   input  logic [hrs_pkg::DATA_W-1:0]    slot_data,
   output logic [hrs_pkg::SN_W-1:0]      min_sn,
   output logic [hrs_pkg::SN_W-1:0]      max_sn,
   output logic                          found,
   output logic [hrs_pkg::DATA_W-1:0]    found_data
);
   import hrs_pkg::*;

   logic              any_ff;
   logic              found_ff;
   logic [SN_W-1:0]   min_ff;
   logic [SN_W-1:0]   max_ff;
   logic [DATA_W-1:0] data_ff;
   logic              lt_min;
   logic              gt_max;
   logic              hit;

   assign lt_min = $signed(slot_sn) < $signed(min_ff);
   assign gt_max = $signed(slot_sn) > $signed(max_ff);
   assign hit    = ctl.lookup && !found_ff && (slot_sn == key);

   always_ff @(posedge clock) begin
      if (reset || ctl.start) begin
         any_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else if (ctl.valid) begin
         any_ff <= 1'b1;
         if (!any_ff || lt_min) begin
            min_ff <= slot_sn;
         end
         if (!any_ff || gt_max) begin
            max_ff <= slot_sn;
         end
         if (hit) begin
            found_ff <= 1'b1;
            data_ff  <= slot_data;
         end
      end
   end

   assign min_sn     = any_ff ? min_ff : SN_UNKNOWN;
   assign max_sn     = any_ff ? max_ff : SN_UNKNOWN;
   assign found      = found_ff;
   assign found_data = found_ff ? data_ff : '0;

endmodule

### src/history_ring_with_seq_search.sv
// A request accepted with N entries stored after its command has acted scans those
// N entries, N running from 0 to DEPTH-1; rsp_valid is then set from ST_DONE once the output is free.
// A new request is taken only in ST_IDLE, once the last response is registered; the
// scan reads one slot per cycle from the single read port of the slot memory.
// Reset (synchronous): head and tail cleared, ring empty; slot memory not cleared.
module history_ring_with_seq_search #(
   parameter int DEPTH = hrs_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hrs_pkg::CMD_W-1:0]     req_command,
   input  logic [hrs_pkg::SN_W-1:0]      req_change_sn,
   input  logic [hrs_pkg::DATA_W-1:0]    req_change_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_full_res,
   output logic [hrs_pkg::SN_W-1:0]      rsp_min_sn,
   output logic [hrs_pkg::SN_W-1:0]      rsp_max_sn,
   output logic                          rsp_found,
   output logic [hrs_pkg::DATA_W-1:0]    rsp_found_data
);
   import hrs_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + 1'b1;
   endfunction

   state_type        state_ff;
   logic [IDX_W-1:0] head_ff, tail_ff, rd_ptr_ff;
   logic [IDX_W-1:0] head_in, tail_in;
   logic             rd_pend_ff;
   logic [CMD_W-1:0] cmd_ff;
   logic [SN_W-1:0]  key_ff;

   logic              rsp_valid_ff;
   logic              full_ff;
   logic [SN_W-1:0]   min_ff, max_ff;
   logic              found_ff;
   logic [DATA_W-1:0] found_data_ff;

   logic              accept;
   logic              rsp_free;
   logic [SLOT_W-1:0] rd_data;
   scan_ctl_type      scan_ctl;
   logic [SN_W-1:0]   scan_min, scan_max;
   logic              scan_found;
   logic [DATA_W-1:0] scan_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      case (req_command)
         CMD_ADD: begin
            head_in = next_idx(head_ff);
            if (head_in == tail_ff) begin
               tail_in = next_idx(tail_ff);
            end
         end
         CMD_DROP: begin
            if (tail_ff != head_ff) begin
               tail_in = next_idx(tail_ff);
            end
         end
         default: begin
         end
      endcase
   end

   hrs_ring_mem #(.DEPTH(DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (accept && (req_command == CMD_ADD)),
      .wr_addr (head_ff),
      .wr_data ({req_change_sn, req_change_data}),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   assign scan_ctl.start  = accept;
   assign scan_ctl.valid  = rd_pend_ff;
   assign scan_ctl.lookup = (cmd_ff == CMD_LOOKUP);

   hrs_scan_unit u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .key        (key_ff),
      .slot_sn    (rd_data[SLOT_W-1:DATA_W]),
      .slot_data  (rd_data[DATA_W-1:0]),
      .min_sn     (scan_min),
      .max_sn     (scan_max),
      .found      (scan_found),
      .found_data (scan_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rd_ptr_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  head_ff   <= head_in;
                  tail_ff   <= tail_in;
                  rd_ptr_ff <= tail_in;
                  cmd_ff    <= req_command;
                  key_ff    <= req_change_sn;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_ptr_ff != head_ff) begin
                  rd_ptr_ff  <= next_idx(rd_ptr_ff);
                  rd_pend_ff <= 1'b1;
               end else begin
                  rd_pend_ff <= 1'b0;
                  state_ff   <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  full_ff       <= (next_idx(head_ff) == tail_ff);
                  min_ff        <= scan_min;
                  max_ff        <= scan_max;
                  found_ff      <= scan_found;
                  found_data_ff <= scan_data;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_full_res   = full_ff;
   assign rsp_min_sn     = min_ff;
   assign rsp_max_sn     = max_ff;
   assign rsp_found      = found_ff;
   assign rsp_found_data = found_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while scan in progress");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

   a_no_read_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_pend_ff)
      else $error("slot read pending while idle");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= IDX_LAST) && (tail_ff <= IDX_LAST))
      else $error("ring index out of range");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import hrs_pkg::*;

   localparam int RING_DEPTH     = DEPTH_DEFAULT;
   localparam int RING_IDX_W     = $clog2(RING_DEPTH);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = RING_DEPTH + 8;
   localparam int MAX_REPORTS    = 10;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [SN_W-1:0]  SN_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [SN_W-1:0]  SN_MIN     = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic              full;
      logic [SN_W-1:0]   min_sn;
      logic [SN_W-1:0]   max_sn;
      logic              found;
      logic [DATA_W-1:0] found_data;
   } ring_status_type;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_command     = CMD_ADD;
   logic [SN_W-1:0]   req_change_sn   = '0;
   logic [DATA_W-1:0] req_change_data = '0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   logic              rsp_full_res;
   logic [SN_W-1:0]   rsp_min_sn;
   logic [SN_W-1:0]   rsp_max_sn;
   logic              rsp_found;
   logic [DATA_W-1:0] rsp_found_data;

   logic [SN_W-1:0]   ring_sn   [RING_DEPTH];
   logic [DATA_W-1:0] ring_data [RING_DEPTH];
   int unsigned       ring_head = 0;
   int unsigned       ring_tail = 0;
   ring_status_type   expected_status_q[$];

   bit idle_on = 1'b1;
   int error_count   = 0;
   int checked_count = 0;
   int stall_cycles  = 0;
   int n_add = 0, n_drop = 0, n_lookup = 0, n_hit = 0, n_unused = 0;
   int n_full = 0, n_overwrite = 0;

   history_ring_with_seq_search #(.DEPTH(RING_DEPTH)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_change_sn   (req_change_sn),
      .req_change_data (req_change_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_full_res    (rsp_full_res),
      .rsp_min_sn      (rsp_min_sn),
      .rsp_max_sn      (rsp_max_sn),
      .rsp_found       (rsp_found),
      .rsp_found_data  (rsp_found_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned ring_next(int unsigned i);
      return (i + 1) % RING_DEPTH;
   endfunction

   function automatic int unsigned ring_count();
      return (ring_head + RING_DEPTH - ring_tail) % RING_DEPTH;
   endfunction

   function automatic ring_status_type predict_ring_step(logic [CMD_W-1:0]  cmd,
                                                         logic [SN_W-1:0]   sn,
                                                         logic [DATA_W-1:0] data);
      ring_status_type st;
      int unsigned     i;
      bit              any;
      st            = '0;
      st.min_sn     = SN_UNKNOWN;
      st.max_sn     = SN_UNKNOWN;
      any           = 1'b0;
      case (cmd)
         CMD_ADD: begin
            n_add++;
            ring_sn[RING_IDX_W'(ring_head)]   = sn;
            ring_data[RING_IDX_W'(ring_head)] = data;
            ring_head                         = ring_next(ring_head);
            if (ring_head == ring_tail) begin
               ring_tail = ring_next(ring_tail);
               n_overwrite++;
            end
         end
         CMD_DROP: begin
            n_drop++;
            if (ring_tail != ring_head)
               ring_tail = ring_next(ring_tail);
         end
         CMD_LOOKUP: begin
            n_lookup++;
            for (i = ring_tail; i != ring_head; i = ring_next(i)) begin
               if (ring_sn[RING_IDX_W'(i)] == sn) begin
                  st.found      = 1'b1;
                  st.found_data = ring_data[RING_IDX_W'(i)];
                  break;
               end
            end
            if (st.found)
               n_hit++;
         end
         default: n_unused++;
      endcase
      for (i = ring_tail; i != ring_head; i = ring_next(i)) begin
         if (!any) begin
            st.min_sn = ring_sn[RING_IDX_W'(i)];
            st.max_sn = ring_sn[RING_IDX_W'(i)];
            any       = 1'b1;
         end else begin
            if ($signed(ring_sn[RING_IDX_W'(i)]) < $signed(st.min_sn))
               st.min_sn = ring_sn[RING_IDX_W'(i)];
            if ($signed(ring_sn[RING_IDX_W'(i)]) > $signed(st.max_sn))
               st.max_sn = ring_sn[RING_IDX_W'(i)];
         end
      end
      st.full = (ring_next(ring_head) == ring_tail);
      if (st.full)
         n_full++;
      return st;
   endfunction

   function automatic logic [SN_W-1:0] interesting_sn();
      case ($urandom_range(0, 7))
         0:       return SN_MAX;
         1:       return SN_MIN;
         2:       return '0;
         3:       return '1;
         4:       return SN_UNKNOWN;
         5:       return SN_UNKNOWN + 64'd1;
         6:       return SN_UNKNOWN - 64'd1;
         default: return 64'd1;
      endcase
   endfunction

   // stored_pct: share of keys taken from the live entries
   function automatic logic [SN_W-1:0] pick_sn(int stored_pct);
      int unsigned           r;
      logic [SN_W-1:0]       v;
      logic [RING_IDX_W-1:0] idx;
      r = $urandom_range(0, 99);
      if (r < stored_pct && ring_count() != 0) begin
         idx = RING_IDX_W'((ring_tail + $urandom_range(0, ring_count() - 1)) % RING_DEPTH);
         return ring_sn[idx];
      end
      if (r < stored_pct + 20)
         return interesting_sn();
      if (r < stored_pct + 45) begin
         v = 64'($urandom_range(0, 15));
         return v - 64'd8;
      end
      return {$urandom, $urandom};
   endfunction

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_request(input logic [CMD_W-1:0]  cmd,
                               input logic [SN_W-1:0]   sn,
                               input logic [DATA_W-1:0] data);
      if (idle_on && $urandom_range(0, 3) == 0)
         pause_sender($urandom_range(1, 16));
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_change_sn   <= sn;
      req_change_data <= data;
      do @(posedge clock); while (!req_ready);
      expected_status_q.push_back(predict_ring_step(cmd, sn, data));
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_ring();
      send_request(CMD_DROP, '0, '0);
      send_request(CMD_UNUSED, SN_UNKNOWN, 32'hFFFF_FFFF);
      send_request(CMD_LOOKUP, SN_UNKNOWN, '0);
   endtask

   task automatic test_extreme_values();
      send_request(CMD_ADD, SN_MAX, 32'hFFFF_FFFF);
      send_request(CMD_ADD, SN_MIN, 32'h0000_0000);
      send_request(CMD_ADD, '0, 32'hA5A5_5A5A);
      send_request(CMD_ADD, '1, 32'h5A5A_A5A5);
      send_request(CMD_ADD, SN_UNKNOWN, 32'h0000_0001);
      send_request(CMD_LOOKUP, SN_UNKNOWN, '0);
      send_request(CMD_LOOKUP, SN_MIN, '1);
      send_request(CMD_LOOKUP, 64'd1, '0);
   endtask

   task automatic test_duplicate_keys();
      send_request(CMD_ADD, '0, 32'h1234_5678);
      send_request(CMD_LOOKUP, '0, '0);
      send_request(CMD_UNUSED, SN_MAX, 32'hFFFF_FFFF);
      send_request(CMD_DROP, '1, '1);
      send_request(CMD_LOOKUP, SN_MAX, '0);
   endtask

   task automatic test_fill_and_overwrite();
      logic [SN_W-1:0] oldest;
      while (ring_count() < RING_DEPTH - 1)
         send_request(CMD_ADD, {$urandom, $urandom}, $urandom);
      oldest = ring_sn[RING_IDX_W'(ring_tail)];
      send_request(CMD_ADD, {$urandom, $urandom}, $urandom);
      send_request(CMD_LOOKUP, oldest, '0);
   endtask

   task automatic run_random_traffic(int n_items, int add_pct, int drop_pct,
                                     int unused_pct);
      int               r;
      logic [CMD_W-1:0] cmd;
      repeat (n_items) begin
         r = $urandom_range(0, 99);
         if (r < add_pct)
            cmd = CMD_ADD;
         else if (r < add_pct + drop_pct)
            cmd = CMD_DROP;
         else if (r < 100 - unused_pct)
            cmd = CMD_LOOKUP;
         else
            cmd = CMD_UNUSED;
         send_request(cmd, pick_sn(cmd == CMD_LOOKUP ? 60 : 0), $urandom);
      end
   endtask

   task automatic test_random_growth();
      run_random_traffic(250, 50, 15, 4);
   endtask

   task automatic test_pause_until_drained();
      wait_until_drained();
      run_random_traffic(20, 40, 20, 5);
      wait_until_drained();
   endtask

   task automatic test_random_shrink();
      run_random_traffic(130, 30, 35, 5);
   endtask

   task automatic test_random_no_idle();
      idle_on = 1'b0;
      run_random_traffic(200, 45, 20, 4);
   endtask

   task automatic note_mismatch(string what, logic [63:0] expected, logic [63:0] actual);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, expected, actual);
   endtask

   initial begin : rsp_ready_gen
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      ring_status_type exp_st;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d responses outstanding",
                     expected_status_q.size());
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (expected_status_q.size() == 0) begin
               note_mismatch("unexpected response", '0, '1);
            end else begin
               exp_st = expected_status_q.pop_front();
               if (rsp_full_res !== exp_st.full)
                  note_mismatch("full_res", 64'(exp_st.full), 64'(rsp_full_res));
               if (rsp_min_sn !== exp_st.min_sn)
                  note_mismatch("min_sn", exp_st.min_sn, rsp_min_sn);
               if (rsp_max_sn !== exp_st.max_sn)
                  note_mismatch("max_sn", exp_st.max_sn, rsp_max_sn);
               if (rsp_found !== exp_st.found)
                  note_mismatch("found", 64'(exp_st.found), 64'(rsp_found));
               if (rsp_found_data !== exp_st.found_data)
                  note_mismatch("found_data", 64'(exp_st.found_data),
                                64'(rsp_found_data));
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_ring();
      test_extreme_values();
      test_duplicate_keys();
      test_fill_and_overwrite();
      test_random_growth();
      test_pause_until_drained();
      test_random_shrink();
      test_random_no_idle();
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Requests: %0d adds (%0d overwrote the oldest), %0d drops,",
               n_add, n_overwrite, n_drop);
      $display("  %0d lookups (%0d hits), %0d unused codes",
               n_lookup, n_hit, n_unused);
      $display("Responses checked: %0d, ring full on %0d, mismatches: %0d",
               checked_count, n_full, error_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
